[hw/rtl/poba_pkg.sv]
// ----------------------------------------------------------------------------
// poba_pkg
// Types and codes shared by the page and object bitmap allocator.
// ----------------------------------------------------------------------------
package poba_pkg;

   localparam int PAGE_W = 4;
   localparam int OBJ_W  = 5;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_ZERO    = 2'd1;
   localparam logic [1:0] ST_NOSPACE = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   typedef struct packed {
      logic        req_type;
      logic [16:0] size_bytes;
      logic [3:0]  page_index;
      logic [4:0]  object_index;
   } req_type_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] result_page;
      logic [4:0] result_object;
      logic [4:0] pages_used;
   } rsp_type_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SCAN_RD,
      S_SCAN,
      S_MULTI,
      S_TAKE,
      S_RUN_RD,
      S_RUN_WAIT,
      S_REL,
      S_RESP
   } state_type;

endpackage

[hw/rtl/poba_ram.sv]
// ----------------------------------------------------------------------------
// poba_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module poba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[hw/rtl/page_object_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// page_object_bitmap_allocator
// Bitmap first-fit page and object allocator with a sequenced search.
// ----------------------------------------------------------------------------
// One transaction at a time. An allocation of up to one page walks the pages
// of the in-use region in order, one object bit per cycle through a run
// counter. A larger allocation checks one page's free flag per cycle and
// marks one page per cycle. A free reads the run length record from the RAM
// and releases one page per cycle. Run length records live in a RAM that a
// pass over all MAX_PAGES * OBJECTS_PER_PAGE entries (512 by default) clears
// after reset, with req_ready low meanwhile; each entry also carries an epoch
// mark of its page, flipped on append.
module page_object_bitmap_allocator
   import poba_pkg::*;
#(
   parameter int MAX_PAGES        = 16,
   parameter int OBJECTS_PER_PAGE = 32,
   parameter int OBJECT_BYTES     = 128,
   parameter int PAGE_BYTES       = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type_type rsp_data
);
   localparam int PW  = $clog2(MAX_PAGES);
   localparam int CW  = $clog2(MAX_PAGES + 1);
   localparam int OW  = $clog2(OBJECTS_PER_PAGE);
   localparam int NW  = $clog2(OBJECTS_PER_PAGE + 1);
   localparam int RLW = $clog2(MAX_PAGES * OBJECTS_PER_PAGE + 1);
   localparam int AW  = $clog2(MAX_PAGES * OBJECTS_PER_PAGE);
   localparam int OBJ_SH  = $clog2(OBJECT_BYTES);
   localparam int PAGE_SH = $clog2(PAGE_BYTES);
   localparam logic [OBJECTS_PER_PAGE-1:0] FULL = '1;

   state_type state_ff, state_in;

   logic [OBJECTS_PER_PAGE-1:0] bits_ff [MAX_PAGES];
   logic [MAX_PAGES-1:0]        epoch_ff, epoch_in;
   logic [CW-1:0]  used_ff, used_in;
   req_type_type   req_ff;
   logic [RLW-1:0] objs_ff, objs_in, left_ff, left_in;
   logic [CW-1:0]  pages_ff, pages_in;
   logic [CW-1:0]  p_ff, p_in, q_ff, q_in;
   logic [NW-1:0]  i_ff, i_in, run_ff, run_in, start_ff, start_in;
   logic [CW-1:0]  fit_ff, fit_in;
   logic [1:0]     status_ff, status_in;
   logic [PW-1:0]  rpage_ff, rpage_in;
   logic [OW-1:0]  robj_ff, robj_in;
   logic           append_ff, append_in;
   logic [AW-1:0]  clr_ff, clr_in;

   // run length RAM: value plus epoch bit
   logic           ram_we;
   logic [AW-1:0]  ram_waddr, ram_raddr;
   logic [RLW:0]   ram_wdata, ram_rdata;

   poba_ram #(.WIDTH(RLW + 1), .DEPTH(MAX_PAGES * OBJECTS_PER_PAGE)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
      .rd_addr(ram_raddr), .rd_data(ram_rdata)
   );

   logic [16:0] sz;
   logic [17:0] objs_w, pages_w;
   logic [OW-1:0] pidx_o;
   logic [PW-1:0] p_idx, q_idx;
   logic [OBJECTS_PER_PAGE-1:0] cur_bits, span;
   logic [RLW-1:0] chunk, rl_val;
   logic           rl_valid;

   assign sz      = req_ff.size_bytes;
   assign objs_w  = (18'(sz) + 18'(OBJECT_BYTES - 1)) >> OBJ_SH;
   assign pages_w = (18'(sz) + 18'(PAGE_BYTES - 1)) >> PAGE_SH;
   assign p_idx   = p_ff[PW-1:0];
   assign q_idx   = q_ff[PW-1:0];
   assign cur_bits = bits_ff[p_idx];
   assign chunk   = (left_ff > RLW'(OBJECTS_PER_PAGE)) ? RLW'(OBJECTS_PER_PAGE) : left_ff;
   assign pidx_o  = req_ff.object_index[OW-1:0];
   assign rl_valid = (ram_rdata[RLW] == epoch_ff[p_idx]) && (ram_rdata[RLW-1:0] != '0);
   assign rl_val  = ram_rdata[RLW-1:0];

   // span from start_ff or 0 (take) or object index (release), clipped at page end
   logic [OW:0] sp_first;
   always_comb begin
      sp_first = (state_ff == S_REL) ? {1'b0, pidx_o} :
                 ((state_ff == S_TAKE && !append_ff && pages_ff == CW'(1))
                  ? start_ff[OW:0] : '0);
      for (int b = 0; b < OBJECTS_PER_PAGE; b++) begin
         span[b] = ((OW+1)'(b) >= sp_first) &&
                   (RLW'(b) < RLW'(sp_first) + chunk);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:  if (clr_ff == AW'(MAX_PAGES * OBJECTS_PER_PAGE - 1)) state_in = S_IDLE;
         S_IDLE:   if (req_valid) state_in = S_DECODE;
         S_DECODE: begin
            if (req_ff.req_type == REQ_FREE) begin
               state_in = (CW'(req_ff.page_index) < used_ff &&
                           32'(req_ff.object_index) < OBJECTS_PER_PAGE)
                          ? S_RUN_RD : S_RESP;
            end else if (sz == '0) begin
               state_in = S_RESP;
            end else if (32'(sz) <= PAGE_BYTES) begin
               state_in = (objs_w <= 18'(OBJECTS_PER_PAGE)) ? S_SCAN_RD : S_RESP;
            end else begin
               state_in = (pages_w <= 18'(MAX_PAGES)) ? S_MULTI : S_RESP;
            end
         end
         S_SCAN_RD: state_in = (p_ff < used_ff) ? S_SCAN :
                               ((used_ff < CW'(MAX_PAGES)) ? S_TAKE : S_RESP);
         S_SCAN: begin
            if (cur_bits[i_ff[OW-1:0]] && run_ff + 1'b1 == objs_ff[NW-1:0])
               state_in = S_TAKE;
            else if (i_ff == NW'(OBJECTS_PER_PAGE - 1))
               state_in = S_SCAN_RD;
         end
         S_MULTI: begin
            if ((CW+1)'(p_ff) + (CW+1)'(pages_ff) > (CW+1)'(used_ff)) begin
               state_in = ((CW+1)'(used_ff) + (CW+1)'(pages_ff) <= (CW+1)'(MAX_PAGES))
                          ? S_TAKE : S_RESP;
            end else if (bits_ff[q_idx] != FULL) begin
            end else if (fit_ff + 1'b1 == pages_ff) begin
               state_in = S_TAKE;
            end
         end
         S_TAKE:     if (q_ff + 1'b1 == p_ff + pages_ff) state_in = S_RESP;
         S_RUN_RD:   state_in = S_RUN_WAIT;
         S_RUN_WAIT: state_in = rl_valid ? S_REL : S_RESP;
         S_REL:      if (left_ff <= RLW'(OBJECTS_PER_PAGE) || q_ff + 1'b1 >= used_ff)
                        state_in = S_RESP;
         S_RESP:     if (rsp_ready) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      objs_in = objs_ff; left_in = left_ff; pages_in = pages_ff;
      p_in = p_ff; q_in = q_ff; i_in = i_ff; run_in = run_ff; start_in = start_ff;
      fit_in = fit_ff; status_in = status_ff; rpage_in = rpage_ff; robj_in = robj_ff;
      append_in = append_ff; used_in = used_ff; epoch_in = epoch_ff;
      clr_in = clr_ff;
      ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0;
      ram_raddr = AW'({p_idx, pidx_o});
      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1; ram_waddr = clr_ff; ram_wdata = '0;
            clr_in = clr_ff + 1'b1;
         end
         S_DECODE: begin
            objs_in = RLW'(objs_w); pages_in = CW'(pages_w); left_in = RLW'(objs_w);
            p_in = '0; q_in = '0; fit_in = '0; i_in = '0; run_in = '0;
            rpage_in = '0; robj_in = '0; append_in = 1'b0; status_in = ST_NOSPACE;
            if (req_ff.req_type == REQ_FREE) begin
               status_in = ST_IGNORED;
               p_in = CW'(req_ff.page_index); q_in = CW'(req_ff.page_index);
            end else if (sz == '0) begin
               status_in = ST_ZERO;
            end else if (32'(sz) > PAGE_BYTES) begin
               pages_in = CW'(pages_w);
            end else begin
               pages_in = CW'(1);
            end
         end
         S_SCAN_RD: begin
            i_in = '0; run_in = '0;
            if (p_ff >= used_ff) begin
               append_in = 1'b1; p_in = used_ff; q_in = used_ff;
            end
         end
         S_SCAN: begin
            i_in = i_ff + 1'b1;
            if (cur_bits[i_ff[OW-1:0]]) begin
               run_in = run_ff + 1'b1;
               if (run_ff == '0) start_in = i_ff;
               if (run_ff + 1'b1 == objs_ff[NW-1:0]) begin
                  q_in = p_ff;
                  if (run_ff == '0) start_in = i_ff;
               end
            end else begin
               run_in = '0;
            end
            if (i_ff == NW'(OBJECTS_PER_PAGE - 1) &&
                !(cur_bits[i_ff[OW-1:0]] && run_ff + 1'b1 == objs_ff[NW-1:0]))
               p_in = p_ff + 1'b1;
         end
         S_MULTI: begin
            if ((CW+1)'(p_ff) + (CW+1)'(pages_ff) > (CW+1)'(used_ff)) begin
               append_in = 1'b1; p_in = used_ff; q_in = used_ff;
            end else if (bits_ff[q_idx] != FULL) begin
               p_in = q_ff + 1'b1; q_in = q_ff + 1'b1; fit_in = '0;
            end else if (fit_ff + 1'b1 == pages_ff) begin
               q_in = p_ff;
            end else begin
               q_in = q_ff + 1'b1; fit_in = fit_ff + 1'b1;
            end
         end
         S_TAKE: begin
            left_in = left_ff - chunk;
            q_in = q_ff + 1'b1;
            if (q_ff == p_ff) begin
               status_in = ST_DONE; rpage_in = p_idx;
               robj_in = (pages_ff == CW'(1) && !append_ff) ? start_ff[OW-1:0] : '0;
               ram_we = 1'b1;
               ram_waddr = AW'({p_idx, ((pages_ff == CW'(1) && !append_ff)
                                        ? start_ff[OW-1:0] : OW'(0))});
               ram_wdata = {append_ff ? ~epoch_ff[p_idx] : epoch_ff[p_idx], objs_ff};
            end
            if (append_ff) begin
               epoch_in[q_idx] = ~epoch_ff[q_idx];
               used_in = used_ff + 1'b1;
            end
         end
         S_RUN_WAIT: begin
            if (rl_valid) begin
               left_in = rl_val; status_in = ST_DONE;
               ram_we = 1'b1; ram_waddr = AW'({p_idx, pidx_o});
               ram_wdata = {epoch_ff[p_idx], RLW'(0)};
            end
         end
         S_REL: begin
            left_in = left_ff - chunk; q_in = q_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         used_ff  <= '0;
         epoch_ff <= '0;
         for (int k = 0; k < MAX_PAGES; k++) bits_ff[k] <= FULL;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         used_ff  <= used_in;
         epoch_ff <= epoch_in;
         if (state_ff == S_TAKE)
            bits_ff[q_idx] <= (append_ff ? FULL : bits_ff[q_idx]) & ~span;
         if (state_ff == S_REL)
            bits_ff[q_idx] <= bits_ff[q_idx] | span;
      end
      if (state_ff == S_IDLE && req_valid) req_ff <= req_data;
      objs_ff <= objs_in; left_ff <= left_in; pages_ff <= pages_in;
      p_ff <= p_in; q_ff <= q_in; i_ff <= i_in; run_ff <= run_in; start_ff <= start_in;
      fit_ff <= fit_in; status_ff <= status_in; rpage_ff <= rpage_in;
      robj_ff <= robj_in; append_ff <= append_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   always_comb begin
      rsp_data.status        = status_ff;
      rsp_data.result_page   = PAGE_W'(rpage_ff);
      rsp_data.result_object = OBJ_W'(robj_ff);
      rsp_data.pages_used    = 5'(used_ff);
   end
endmodule

[tb/sv/alloc_checker.sv]
// ----------------------------------------------------------------------------
// alloc_checker
// Watches the request and response channels of the page allocator, predicts
// each response from its own copy of the pool and compares field by field.
// ----------------------------------------------------------------------------
module alloc_checker
   import poba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_type_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_type_type rsp_data,
   output int           fail_count,
   output int           pending
);

   localparam int NPAGES = 16;
   localparam int NOBJS  = 32;
   localparam int OBYTES = 128;
   localparam int PBYTES = 4096;

   logic [31:0] pool_bits [NPAGES];
   int          pool_cnt  [NPAGES];
   int          run_len   [NPAGES*NOBJS];
   int          region_pages;
   rsp_type_type rsp_queue [$];

   function automatic logic [31:0] span(int first, int count);
      logic [31:0] m;
      m = '0;
      for (int i = 0; i < count; i++)
         if (first + i < NOBJS) m[first+i] = 1'b1;
      return m;
   endfunction

   task automatic mark_used(int pg, int first, int count);
      pool_bits[pg] &= ~span(first, count);
      pool_cnt[pg] = $countones(pool_bits[pg]);
   endtask

   task automatic clear_page(int pg);
      pool_bits[pg] = '1;
      pool_cnt[pg] = NOBJS;
      for (int i = 0; i < NOBJS; i++) run_len[pg*NOBJS+i] = 0;
   endtask

   function automatic int first_fit(int pg, int n);
      int run, start;
      run = 0;
      start = 0;
      for (int i = 0; i < NOBJS; i++) begin
         if (pool_bits[pg][i]) begin
            if (run == 0) start = i;
            run++;
            if (run == n) return start;
         end else begin
            run = 0;
         end
      end
      return -1;
   endfunction

   task automatic mark_pages(int pg, int pages, int objs);
      int left, c;
      left = objs;
      for (int i = 0; i < pages; i++) begin
         c = left > NOBJS ? NOBJS : left;
         mark_used(pg + i, 0, c);
         left -= c;
      end
      run_len[pg*NOBJS] = objs;
   endtask

   task automatic pool_reset();
      for (int p = 0; p < NPAGES; p++) clear_page(p);
      region_pages = 0;
   endtask

   task automatic predict_alloc(input req_type_type rq, output rsp_type_type rs);
      int size, objs, pages, s, left, c, q, o;
      bit found, ok;
      rs = '0;
      if (rq.req_type == REQ_ALLOC) begin
         size = int'(rq.size_bytes);
         found = 0;
         if (size == 0) begin
            rs.status = ST_ZERO;
         end else begin
            objs = (size + OBYTES - 1) / OBYTES;
            pages = (size + PBYTES - 1) / PBYTES;
            if (size <= PBYTES) begin
               for (int p = 0; p < region_pages && !found; p++) begin
                  s = first_fit(p, objs);
                  if (s >= 0) begin
                     mark_used(p, s, objs);
                     run_len[p*NOBJS+s] = objs;
                     rs.result_page = 4'(p);
                     rs.result_object = 5'(s);
                     found = 1;
                  end
               end
               if (!found && region_pages < NPAGES) begin
                  clear_page(region_pages);
                  mark_used(region_pages, 0, objs);
                  run_len[region_pages*NOBJS] = objs;
                  rs.result_page = 4'(region_pages);
                  region_pages++;
                  found = 1;
               end
            end else if (pages <= NPAGES) begin
               for (int p = 0; p + pages <= region_pages && !found; p++) begin
                  ok = 1;
                  for (int k = 0; k < pages; k++)
                     if (pool_cnt[p+k] < NOBJS) ok = 0;
                  if (ok) begin
                     mark_pages(p, pages, objs);
                     rs.result_page = 4'(p);
                     found = 1;
                  end
               end
               if (!found && region_pages + pages <= NPAGES) begin
                  for (int k = 0; k < pages; k++) clear_page(region_pages + k);
                  mark_pages(region_pages, pages, objs);
                  rs.result_page = 4'(region_pages);
                  region_pages += pages;
                  found = 1;
               end
            end
            rs.status = found ? ST_DONE : ST_NOSPACE;
         end
      end else begin
         rs.status = ST_IGNORED;
         q = int'(rq.page_index);
         o = int'(rq.object_index);
         if (q < region_pages && run_len[q*NOBJS+o] != 0) begin
            left = run_len[q*NOBJS+o];
            run_len[q*NOBJS+o] = 0;
            while (left > 0 && q < region_pages) begin
               c = left > NOBJS ? NOBJS : left;
               pool_bits[q] |= span(o, c);
               pool_cnt[q] = $countones(pool_bits[q]);
               left -= c;
               q++;
            end
            rs.status = ST_DONE;
         end
      end
      rs.pages_used = 5'(region_pages);
   endtask

   assign pending = rsp_queue.size();

   always @(posedge clock) begin
      rsp_type_type exp_rsp;
      if (reset) begin
         pool_reset();
         rsp_queue.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_queue.size() == 0) begin
               $error("unexpected response transaction %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = rsp_queue.pop_front();
               if (rsp_data !== exp_rsp) begin
                  if (rsp_data.status !== exp_rsp.status)
                     $error("status exp %0d got %0d", exp_rsp.status, rsp_data.status);
                  if (rsp_data.result_page !== exp_rsp.result_page)
                     $error("result_page exp %0d got %0d", exp_rsp.result_page,
                            rsp_data.result_page);
                  if (rsp_data.result_object !== exp_rsp.result_object)
                     $error("result_object exp %0d got %0d", exp_rsp.result_object,
                            rsp_data.result_object);
                  if (rsp_data.pages_used !== exp_rsp.pages_used)
                     $error("pages_used exp %0d got %0d", exp_rsp.pages_used,
                            rsp_data.pages_used);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_alloc(req_data, exp_rsp);
            rsp_queue.push_back(exp_rsp);
         end
      end
   end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and free transactions into the page allocator under
// varying back-pressure; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import poba_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_type_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_type_type rsp_data;
   int           fail_count;
   int           pending;

   int send_idle_pct;
   int recv_idle_pct;
   int sent_count;

   // live allocations so that frees mostly hit real runs
   logic [3:0] live_page [$];
   logic [4:0] live_obj  [$];

   page_object_bitmap_allocator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   alloc_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("tb: failure");
      $finish;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // sample successful responses, frees included, so later frees can target them
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_data.status == ST_DONE
          && live_page.size() < 64 && $urandom_range(1)) begin
         live_page.push_back(rsp_data.result_page);
         live_obj.push_back(rsp_data.result_object);
      end
   end

   task automatic send_item(input req_type_type rq);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_valid <= 1'b0;
      sent_count++;
      // the block is busy right after a transaction, so this costs no rate
      @(posedge clock);
   endtask

   function automatic req_type_type make_alloc(int size);
      req_type_type rq;
      rq = '0;
      rq.req_type = REQ_ALLOC;
      rq.size_bytes = 17'(size);
      rq.page_index = 4'($urandom);
      rq.object_index = 5'($urandom);
      return rq;
   endfunction

   function automatic req_type_type make_free(int pg, int ob);
      req_type_type rq;
      rq = '0;
      rq.req_type = REQ_FREE;
      rq.size_bytes = 17'($urandom);
      rq.page_index = 4'(pg);
      rq.object_index = 5'(ob);
      return rq;
   endfunction

   function automatic int rand_size();
      int r;
      r = $urandom_range(99);
      if (r < 55) return $urandom_range(1, 1024);
      if (r < 75) return $urandom_range(1025, 4096);
      if (r < 90) return $urandom_range(4097, 16384);
      if (r < 95) return $urandom_range(16385, 65536);
      return $urandom_range(0, 131071);
   endfunction

   task automatic random_phase(int count);
      int r, k;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 50) begin
            send_item(make_alloc(rand_size()));
         end else if (r < 85 && live_page.size() > 0) begin
            k = $urandom_range(live_page.size() - 1);
            send_item(make_free(int'(live_page[k]), int'(live_obj[k])));
            live_page.delete(k);
            live_obj.delete(k);
         end else begin
            send_item(make_free($urandom, $urandom));
         end
      end
   endtask

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      reset = 1'b1;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      sent_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero size, extremes, multi-page, no space, bad frees
      send_item(make_alloc(0));
      send_item(make_free(0, 0));
      send_item(make_alloc(1));
      send_item(make_alloc(128));
      send_item(make_alloc(129));
      send_item(make_alloc(4096));
      send_item(make_alloc(4097));
      send_item(make_free(0, 0));
      send_item(make_free(0, 1));
      send_item(make_free(0, 3));
      send_item(make_free(15, 31));
      send_item(make_alloc(131071));
      send_item(make_alloc(65537));
      send_item(make_alloc(65536));
      send_item(make_free(3, 0));
      send_item(make_free(0, 1));
      send_item(make_alloc(65536));
      send_item(make_alloc(12000));
      for (int i = 0; i < 4; i++) send_item(make_alloc(4096));
      send_item(make_free(2, 0));
      send_item(make_alloc(100));
      send_item(make_free(15, 0));

      // sender holds off until the pipeline drains
      while (pending != 0) @(posedge clock);

      send_idle_pct = 31;
      recv_idle_pct = 70;
      random_phase(350);
      send_idle_pct = 70;
      recv_idle_pct = 31;
      random_phase(350);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(330);

      while (pending != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      $display("covered %0d transactions: zero size, multi-page, pool full, bad frees",
               sent_count);
      $display("idle mixes 31/70, 70/31 and none");
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/poba_pkg.sv
hw/rtl/poba_ram.sv
hw/rtl/page_object_bitmap_allocator.sv
tb/sv/alloc_checker.sv
tb/sv/testbench.sv
